### rtl/bm3_pkg.sv
`default_nettype none

package bm3_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = COL_W + 1;
    localparam int MAX_HEIGHT = 1024;
    localparam int HGT_W      = 11;
    localparam int ROW_W      = 10;
    localparam int OUT_DIM_W  = 10;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int MASK_W     = 9;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

    localparam logic MODE_DILATE = 1'b0;
    localparam logic MODE_ERODE  = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Window bit groups: bit 3*row+col, row 0 above, col 0 left.
    localparam logic [MASK_W-1:0] KEEP_LEFT_TWO   = 9'h0DB;
    localparam logic [MASK_W-1:0] TOP_ROW_BITS    = 9'h007;
    localparam logic [MASK_W-1:0] BOTTOM_ROW_BITS = 9'h1C0;
    localparam int                CENTRE_BIT      = 4;

    localparam logic [MASK_W-1:0]     MASK_RESET   = 9'h1FF;
    localparam logic [WID_W-1:0]      WIDTH_RESET  = WID_W'(MAX_WIDTH);
    localparam logic [HGT_W-1:0]      HEIGHT_RESET = HGT_W'(MAX_HEIGHT);

    typedef logic [COL_W-1:0] col_t;

    // Scan position flags handed from the counters to the window logic.
    typedef struct packed {
        logic step;        // item advances the scan
        logic col_zero;    // item lands in column zero
        logic restart;     // frame restarts after this cycle
        logic row_top;     // result row is the first row
        logic row_bottom;  // result row is the last row
    } bm3_scan_t;

    function automatic logic [WID_W-1:0] clamp_width(logic [CFG_DATA_W-1:0] v);
        logic [WID_W-1:0] r;
        if (v == '0) begin
            r = WID_W'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            r = WID_W'(MAX_WIDTH);
        end else begin
            r = WID_W'(v);
        end
        return r;
    endfunction

    function automatic logic [HGT_W-1:0] clamp_height(logic [CFG_DATA_W-1:0] v);
        logic [HGT_W-1:0] r;
        if (v == '0) begin
            r = HGT_W'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            r = HGT_W'(MAX_HEIGHT);
        end else begin
            r = HGT_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/bm3_line_buf.sv
`default_nettype none

// Two line stores held as one two-bit wide memory: bit 1 is the upper line,
// bit 0 the lower line. Read data is registered, with write-to-read bypass.
module bm3_line_buf (
    input  wire logic                aclk,
    input  wire logic                wr_en,
    input  wire bm3_pkg::col_t       wr_addr,
    input  wire logic [1:0]          wr_data,
    input  wire bm3_pkg::col_t       rd_addr,
    output logic [1:0]               rd_data
);
    import bm3_pkg::*;

    logic [1:0] mem [MAX_WIDTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/bm3_scan_ctrl.sv
`default_nettype none

// Input and output raster counters, result release and end of frame.
module bm3_scan_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_restart,
    input  wire logic                         accept,
    input  wire logic                         kind,
    input  wire logic                         pixel,
    input  wire logic [bm3_pkg::WID_W-1:0]    width,
    input  wire logic [bm3_pkg::HGT_W-1:0]    height,
    output bm3_pkg::col_t                     rd_addr,
    output bm3_pkg::col_t                     wr_addr,
    output logic                              pix_eff,
    output bm3_pkg::bm3_scan_t                scan,
    output logic                              emit,
    output logic                              last,
    output bm3_pkg::col_t                     out_col,
    output logic [bm3_pkg::ROW_W-1:0]         out_row
);
    import bm3_pkg::*;

    col_t             in_col_reg,  in_col_next;
    logic [HGT_W-1:0] in_row_reg,  in_row_next;
    col_t             out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic             frame_in;
    logic             step;
    logic [WID_W-1:0] col_inc;
    logic             col_wrap;
    logic [WID_W-1:0] ocol_inc;
    logic             ocol_wrap;
    logic [HGT_W-1:0] orow_inc;
    logic             row_bottom;
    logic             frame_done;

    assign frame_in   = in_row_reg < height;
    // A drain word while pixels are still due is dropped entirely.
    assign step       = accept && !((kind == KIND_DRAIN) && frame_in);
    assign pix_eff    = (kind == KIND_PIXEL) && frame_in && pixel;

    assign col_inc    = WID_W'(in_col_reg) + WID_W'(1);
    assign col_wrap   = col_inc >= width;
    assign ocol_inc   = WID_W'(out_col_reg) + WID_W'(1);
    assign ocol_wrap  = ocol_inc >= width;
    assign orow_inc   = HGT_W'(out_row_reg) + HGT_W'(1);
    assign row_bottom = orow_inc >= height;

    // Results start once one full row plus one pixel has arrived.
    assign emit = step && ((in_row_reg >= HGT_W'(2)) ||
                           ((in_row_reg == HGT_W'(1)) && (in_col_reg != '0)));
    assign last       = row_bottom && ocol_wrap;
    assign frame_done = emit && last;

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_restart || frame_done) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (step) begin
            if (col_wrap) begin
                in_col_next = '0;
                in_row_next = in_row_reg + HGT_W'(1);
            end else begin
                in_col_next = col_inc[COL_W-1:0];
            end
            if (emit) begin
                if (ocol_wrap) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end else begin
                    out_col_next = ocol_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign rd_addr = in_col_next;
    assign wr_addr = in_col_reg;
    assign out_col = out_col_reg;
    assign out_row = out_row_reg;

    assign scan.step       = step;
    assign scan.col_zero   = (in_col_reg == '0);
    assign scan.restart    = cfg_restart || frame_done;
    assign scan.row_top    = (out_row_reg == '0);
    assign scan.row_bottom = row_bottom;

endmodule

`default_nettype wire

### rtl/bm3_window_eval.sv
`default_nettype none

// 3x3 window register and the dilate / erode decision.
module bm3_window_eval (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bm3_pkg::bm3_scan_t            scan,
    input  wire logic                          up,
    input  wire logic                          lo,
    input  wire logic                          pix,
    input  wire logic                          mode,
    input  wire logic [bm3_pkg::MASK_W-1:0]    mask,
    output logic                               pixel_out
);
    import bm3_pkg::*;

    logic [MASK_W-1:0] win_reg, win_next;
    logic [MASK_W-1:0] shifted;
    logic [MASK_W-1:0] newcol;
    logic [MASK_W-1:0] merged;
    logic [MASK_W-1:0] eval_win;
    logic [MASK_W-1:0] masked;
    logic [MASK_W-1:0] hits;

    assign shifted = (win_reg >> 1) & KEEP_LEFT_TWO;
    assign newcol  = {pix, 2'b00, lo, 2'b00, up, 2'b00};
    assign merged  = shifted | newcol;

    // At column zero the result belongs to the previous row's last pixel,
    // whose right-hand column lies outside the frame.
    assign eval_win = scan.col_zero ? shifted : merged;

    always_comb begin
        win_next = win_reg;
        if (scan.restart) begin
            win_next = '0;
        end else if (scan.step) begin
            win_next = scan.col_zero ? newcol : merged;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else begin
            win_reg <= win_next;
        end
    end

    always_comb begin
        masked = eval_win;
        if (scan.row_top) begin
            masked = masked & ~TOP_ROW_BITS;
        end
        if (scan.row_bottom) begin
            masked = masked & ~BOTTOM_ROW_BITS;
        end
    end

    assign hits = masked & mask;

    always_comb begin
        case (mode)
            MODE_DILATE: pixel_out = (hits != '0);
            MODE_ERODE:  pixel_out = (hits == mask) && masked[CENTRE_BIT];
            default:     pixel_out = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/binary_morphology_3x3.sv
// Results: a result word is valid in the cycle after the input word that releases it;
// results trail the pixels by one image row plus one pixel, drained by drain words.
// Throughput: one input word and one result word per cycle while no result word is stalled,
// set by the single registered pass from the line store read register to the result register.
// Reset: synchronous, active low; clears configuration to defaults, the counters,
// the window and the result valid. Line store contents are not cleared.
`default_nettype none

module binary_morphology_3x3 (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port.
    input  wire logic                              cfg_we,
    input  wire logic [bm3_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [bm3_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,  // [0] pixel_in
    input  wire logic                              s_tuser,  // kind
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [23:0]                            m_tdata,  // [0] pixel_out, [10:1] out_col,
                                                             // [20:11] out_row
    output logic                                   m_tlast   // frame_last
);
    import bm3_pkg::*;

    // Configuration registers. Geometry is stored already clamped to its
    // legal range, so the datapath never sees a zero or oversized value.
    logic              mode_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [WID_W-1:0]  width_reg;
    logic [HGT_W-1:0]  height_reg;
    logic              cfg_restart;

    // A write to either geometry register starts a fresh frame.
    assign cfg_restart = cfg_we && ((cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_DILATE;
            mask_reg   <= MASK_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_MODE:   mode_reg   <= cfg_wdata[0];
                REG_MASK:   mask_reg   <= cfg_wdata[MASK_W-1:0];
                REG_WIDTH:  width_reg  <= clamp_width(cfg_wdata);
                REG_HEIGHT: height_reg <= clamp_height(cfg_wdata);
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    // The result register frees itself whenever the downstream side takes
    // the word, so a new input word is taken in the same cycle.
    logic m_tvalid_reg;
    logic accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Raster counters.
    col_t              rd_addr;
    col_t              wr_addr;
    logic              pix_eff;
    bm3_scan_t         scan;
    logic              emit;
    logic              last;
    col_t              out_col;
    logic [ROW_W-1:0]  out_row;

    bm3_scan_ctrl u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_restart (cfg_restart),
        .accept      (accept),
        .kind        (s_tuser),
        .pixel       (s_tdata[0]),
        .width       (width_reg),
        .height      (height_reg),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .pix_eff     (pix_eff),
        .scan        (scan),
        .emit        (emit),
        .last        (last),
        .out_col     (out_col),
        .out_row     (out_row)
    );

    // Line stores. The read for the next column is issued ahead from the next counter
    // value into the read register, so the two older rows of the current column are
    // ready when the word arrives. Each pixel moves the lower line into the upper one.
    logic [1:0] lines;

    bm3_line_buf u_lines (
        .aclk    (aclk),
        .wr_en   (scan.step),
        .wr_addr (wr_addr),
        .wr_data ({lines[0], pix_eff}),
        .rd_addr (rd_addr),
        .rd_data (lines)
    );

    // Window and morphology decision.
    logic pixel_out;

    bm3_window_eval u_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scan      (scan),
        .up        (lines[1]),
        .lo        (lines[0]),
        .pix       (pix_eff),
        .mode      (mode_reg),
        .mask      (mask_reg),
        .pixel_out (pixel_out)
    );

    // Result register.
    logic                 pixel_out_reg;
    logic [OUT_DIM_W-1:0] out_col_reg;
    logic [OUT_DIM_W-1:0] out_row_reg;
    logic                 last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= emit;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            pixel_out_reg <= pixel_out;
            out_col_reg   <= OUT_DIM_W'(out_col);
            out_row_reg   <= OUT_DIM_W'(out_row);
            last_reg      <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_row_reg, out_col_reg, pixel_out_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

### rtl/bm3_checker.sv
`default_nettype none

module bm3_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic        m_tlast
);

    // A stalled result word holds still until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // With the result register empty the block always takes input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // A stalled result word stalls the input side.
    a_stall_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result word stalled");

    // Reset leaves no result word pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind binary_morphology_3x3 bm3_checker u_bm3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### dv/binary_morphology_3x3_tb.sv
`timescale 1ns / 100ps

module binary_morphology_3x3_tb;

    import bm3_pkg::*;

    // One result pixel as it should leave the block.
    typedef struct packed {
        logic       px;
        logic [9:0] col;
        logic [9:0] row;
        logic       last;
    } morph_pixel_t;

    // Tracks the scan position, the two line stores and the 3x3 window the same
    // way the block does, and keeps the result pixels that are owed but not yet seen.
    class morph_tracker;
        bit           mode;
        bit [8:0]     mask;
        bit [10:0]    width_reg;
        bit [10:0]    height_reg;
        bit           upper_line [MAX_WIDTH];
        bit           lower_line [MAX_WIDTH];
        bit [8:0]     win;
        int unsigned  col_pos;
        int unsigned  row_pos;
        int unsigned  emitted;
        morph_pixel_t due_pixels[$];
        int           bad_count;

        function new();
            mode       = MODE_DILATE;
            mask       = MASK_RESET;
            width_reg  = 11'(MAX_WIDTH);
            height_reg = 11'(MAX_HEIGHT);
            bad_count  = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            win     = '0;
            col_pos = 0;
            row_pos = 0;
            emitted = 0;
        endfunction

        function int outstanding();
            return due_pixels.size();
        endfunction

        task note_mismatch(string msg);
            bad_count++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_MODE: begin
                    mode = val[0];
                end
                REG_MASK: begin
                    mask = val[8:0];
                end
                REG_WIDTH: begin
                    width_reg = val;
                    clear_scan();
                end
                REG_HEIGHT: begin
                    height_reg = val;
                    clear_scan();
                end
                default: begin
                end
            endcase
        endfunction

        // One accepted input word: advance the scan and owe a result if one is due.
        function void take_word(logic knd, logic px);
            int unsigned  w, h, c, p, orow;
            bit           up, lo, pin;
            bit [8:0]     seen, hits;
            morph_pixel_t r;
            w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
            h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
            // Drain words only count once the whole frame is in.
            if (knd == KIND_DRAIN && row_pos < h) return;
            pin = (knd == KIND_PIXEL && row_pos < h) ? px : 1'b0;
            c   = (col_pos >= w) ? w - 1 : col_pos;
            up  = upper_line[c];
            lo  = lower_line[c];
            upper_line[c] = lo;
            lower_line[c] = pin;
            if (c == 0) begin
                seen = (win >> 1) & KEEP_LEFT_TWO;
                win  = {pin, 2'b00, lo, 2'b00, up, 2'b00};
            end else begin
                win  = ((win >> 1) & KEEP_LEFT_TWO) | {pin, 2'b00, lo, 2'b00, up, 2'b00};
                seen = win;
            end
            p       = row_pos * w + c;
            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (p < w + 1) return;
            orow   = emitted / w;
            r.row  = 10'(orow);
            r.col  = 10'(emitted % w);
            r.last = (emitted + 1 >= w * h);
            // Rows outside the frame read as zero.
            if (orow == 0) seen &= ~TOP_ROW_BITS;
            if (orow + 1 >= h) seen &= ~BOTTOM_ROW_BITS;
            hits = seen & mask;
            if (mode == MODE_DILATE) begin
                r.px = |hits;
            end else begin
                r.px = (hits == mask) ? seen[CENTRE_BIT] : 1'b0;
            end
            due_pixels = {due_pixels, r};
            emitted++;
            if (r.last) clear_scan();
        endfunction

        task check_word(logic [23:0] data, logic lastbit);
            morph_pixel_t want;
            if (due_pixels.size() == 0) begin
                note_mismatch($sformatf("result word 0x%06h with none owed", data));
                return;
            end
            want = due_pixels.pop_front();
            if (data[0] !== want.px) begin
                note_mismatch($sformatf("pixel_out %b, want %b at row %0d col %0d",
                                        data[0], want.px, want.row, want.col));
            end
            if (data[10:1] !== want.col) begin
                note_mismatch($sformatf("out_col %0d, want %0d", data[10:1], want.col));
            end
            if (data[20:11] !== want.row) begin
                note_mismatch($sformatf("out_row %0d, want %0d", data[20:11], want.row));
            end
            if (lastbit !== want.last) begin
                note_mismatch($sformatf("frame_last %b, want %b at row %0d col %0d",
                                        lastbit, want.last, want.row, want.col));
            end
        endtask
    endclass

    localparam int RANDOM_WORDS  = 880;
    // Widest frame the random phases use.
    localparam int FILL_WIDTH    = 64;
    // Cycles to let pass after the last owed result before touching a register;
    // a drain word can still be in the pipe without owing anything.
    localparam int SETTLE_CYCLES = 4;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [0] pixel_in
    logic                  s_tuser   = 1'b0; // kind
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;          // [0] pixel_out, [10:1] out_col, [20:11] out_row
    logic                  m_tlast;          // frame_last

    morph_tracker sb;
    bit           tx_steady = 1'b0;
    bit           rx_steady = 1'b0;
    int           rx_hold   = 0;
    int           fed_words = 0;

    binary_morphology_3x3 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Everything the block takes or gives is observed here at the rising edge,
    // with the values settled before the edge. A result is registered and so always leaves
    // after the word that caused it, so the order within this block is safe.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) sb.write_reg(cfg_idx, cfg_wdata);
            if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
            if (s_tvalid && s_tready) sb.take_word(s_tuser, s_tdata[0]);
        end
    end

    // Result side back-pressure: mostly short stalls, now and then a long one,
    // and whole phases where the sink never stalls.
    always @(posedge aclk) begin : rx_pace
        int r;
        r = $urandom_range(0, 99);
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (rx_steady) begin
            m_tready <= 1'b1;
        end else if (r < 15) begin
            rx_hold = (r < 2) ? $urandom_range(10, 40) : $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [8:0] pick_mask();
        case ($urandom_range(0, 5))
            0:       return 9'h000;
            1:       return MASK_RESET;
            2:       return 9'(1) << $urandom_range(0, 8);
            default: return 9'($urandom);
        endcase
    endfunction

    function automatic int pick_density();
        case ($urandom_range(0, 2))
            0:       return 10;
            1:       return 50;
            default: return 90;
        endcase
    endfunction

    // Present one word and hold it until the block takes it. Returns at the edge
    // of acceptance with tvalid still high, so the next word follows without a bubble.
    task automatic send_word(input logic knd, input logic px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= knd;
        s_tdata  <= {7'b0, px};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Wait until every owed result has left, then let the settle time pass as well.
    task automatic settle();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
            #1;
        end while (sb.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves the write enable high so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
    endtask

    // One frame of w by h pixels followed by the w+1 drain words that push out
    // the trailing results. With noise on, early drains (ignored), pixels that
    // land in a full frame (they act as drains), mask and mode changes in the
    // middle of a frame, and the odd restart of the frame are mixed in.
    task automatic run_frame(input int w, input int h, input int density, input bit noisy);
        int k;
        for (k = 0; k < w * h; k++) begin
            if (noisy && $urandom_range(0, 99) < 3) begin
                send_word(KIND_DRAIN, 1'($urandom));
            end
            if (noisy && k > 0 && $urandom_range(0, 199) == 0) begin
                settle();
                write_reg(REG_MODE, $urandom_range(0, 1) ? 11'(MODE_ERODE) : 11'(MODE_DILATE));
                write_reg(REG_MASK, 11'(pick_mask()));
                end_writes();
            end
            if (noisy && k > 0 && $urandom_range(0, 399) == 0) begin
                // Rewriting the height throws the partial frame away.
                settle();
                write_reg(REG_HEIGHT, 11'(h));
                end_writes();
                return;
            end
            send_word(KIND_PIXEL, $urandom_range(0, 99) < density);
            fed_words++;
        end
        for (k = 0; k <= w; k++) begin
            if (noisy && $urandom_range(0, 4) == 0) begin
                send_word(KIND_PIXEL, 1'($urandom));
            end else begin
                send_word(KIND_DRAIN, 1'($urandom));
            end
            fed_words++;
        end
    endtask

    initial begin : stimulus
        int w, h, raw_w, raw_h, k;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // First frame at the widest width used later and one row; a zero height
        // clamps to one row. This pass plus its drain writes every line store
        // entry that later frames read, so none of them reads a stale one.
        write_reg(REG_WIDTH, 11'(FILL_WIDTH));
        write_reg(REG_HEIGHT, 11'd0);
        write_reg(REG_MODE, 11'(MODE_ERODE));
        write_reg(REG_MASK, 11'(pick_mask()));
        end_writes();
        run_frame(FILL_WIDTH, 1, 50, 1'b0);

        // Directed: 3 by 3 dilation with the full mask and two set corners.
        // An early drain at the start and another inside the frame are ignored;
        // a pixel sent after the frame is complete stands in for the first drain.
        settle();
        write_reg(REG_MODE, 11'(MODE_DILATE));
        write_reg(REG_MASK, 11'(MASK_RESET));
        write_reg(REG_WIDTH, 11'd3);
        write_reg(REG_HEIGHT, 11'd3);
        end_writes();
        send_word(KIND_DRAIN, 1'b1);
        send_word(KIND_PIXEL, 1'b1);
        send_word(KIND_PIXEL, 1'b0);
        send_word(KIND_PIXEL, 1'b0);
        send_word(KIND_PIXEL, 1'b0);
        send_word(KIND_PIXEL, 1'b0);
        send_word(KIND_DRAIN, 1'b0);
        send_word(KIND_PIXEL, 1'b0);
        send_word(KIND_PIXEL, 1'b0);
        send_word(KIND_PIXEL, 1'b0);
        send_word(KIND_PIXEL, 1'b1);
        send_word(KIND_PIXEL, 1'b1);
        repeat (3) send_word(KIND_DRAIN, 1'b0);

        // Directed: 2 by 2 erosion with an empty mask, which passes the centre.
        settle();
        write_reg(REG_MODE, 11'(MODE_ERODE));
        write_reg(REG_MASK, 11'h000);
        write_reg(REG_WIDTH, 11'd2);
        write_reg(REG_HEIGHT, 11'd2);
        end_writes();
        send_word(KIND_PIXEL, 1'b1);
        send_word(KIND_PIXEL, 1'b1);
        send_word(KIND_PIXEL, 1'b0);
        send_word(KIND_PIXEL, 1'b1);
        repeat (3) send_word(KIND_DRAIN, 1'b1);

        // Random phases: a fresh setting, then one or two frames of random
        // content. Most frames are tiny so that edges and corners dominate.
        fed_words = 0;
        while (fed_words < RANDOM_WORDS) begin
            k = $urandom_range(0, 99);
            w = (k < 75) ? $urandom_range(1, 8) : (k < 95) ? $urandom_range(9, 32)
                                                           : $urandom_range(33, FILL_WIDTH);
            h = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 16);
            raw_w = (w == 1 && $urandom_range(0, 1)) ? 0 : w;
            raw_h = (h == 1 && $urandom_range(0, 1)) ? 0 : h;
            settle();
            write_reg(REG_MODE, $urandom_range(0, 1) ? 11'(MODE_ERODE) : 11'(MODE_DILATE));
            write_reg(REG_MASK, 11'(pick_mask()));
            write_reg(REG_WIDTH, 11'(raw_w));
            write_reg(REG_HEIGHT, 11'(raw_h));
            end_writes();
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 2)) run_frame(w, h, pick_density(), 1'b1);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Let the owed results come out, with a bound, then look for leftovers.
        s_tvalid <= 1'b0;
        for (k = 0; k < 4000 && sb.outstanding() != 0; k++) begin
            @(posedge aclk);
            #1;
        end
        repeat (8) @(posedge aclk);
        if (sb.outstanding() != 0) begin
            sb.note_mismatch($sformatf("%0d result words never arrived", sb.outstanding()));
        end
        if (sb.bad_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/bm3_pkg.sv
rtl/bm3_line_buf.sv
rtl/bm3_scan_ctrl.sv
rtl/bm3_window_eval.sv
rtl/binary_morphology_3x3.sv
rtl/bm3_checker.sv
dv/binary_morphology_3x3_tb.sv
